[src/lnc_pkg.sv]
// Package for the node cache tag store: sizes, request kinds, result word
// and the structs passed between the sequencer and the scan unit.
// No dependencies.
package lnc_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int ID_W       = 31;
  localparam int KIND_W     = 2;
  localparam int OUT_SLOT_W = 4;

  localparam logic [KIND_W-1:0] KIND_FETCH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CREATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MARK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd3;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SLOT_W-1:0] rank_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ID_W-1:0]   id_t;

  typedef struct packed {
    logic                  hit;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  read_from_store;
    logic                  clear_entry;
    logic                  write_back;
    id_t                   write_id;
    logic [OUT_SLOT_W-1:0] write_slot;
    logic                  null_ref;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic  start;
    logic  step;
    slot_t idx;
    logic  slot_valid;
    rank_t slot_rank;
  } scan_ctl_t;

  typedef struct packed {
    logic  hit;
    slot_t hit_slot;
    logic  free_found;
    slot_t free_slot;
    slot_t min_slot;
  } scan_res_t;

endpackage

[src/lnc_tag_ram.sv]
// Node number store, one entry per slot, one write and one registered read
// port. Depends on lnc_pkg for sizes.
module lnc_tag_ram (
  input  logic          clk,
  input  logic          we,
  input  lnc_pkg::slot_t waddr,
  input  lnc_pkg::id_t   wdata,
  input  lnc_pkg::slot_t raddr,
  output lnc_pkg::id_t   rdata
);

  lnc_pkg::id_t mem [lnc_pkg::SLOTS];
  lnc_pkg::id_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/lnc_scan_unit.sv]
// Shared compare unit: takes one slot per step and keeps the first match,
// the first free slot and the least recent slot. Depends on lnc_pkg.
module lnc_scan_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  lnc_pkg::scan_ctl_t  ctl,
  input  lnc_pkg::id_t        node,
  input  lnc_pkg::id_t        target,
  output lnc_pkg::scan_res_t  res
);

  logic           hit_r, hit_nxt;
  lnc_pkg::slot_t hit_slot_r, hit_slot_nxt;
  logic           free_r, free_nxt;
  lnc_pkg::slot_t free_slot_r, free_slot_nxt;
  lnc_pkg::rank_t min_rank_r, min_rank_nxt;
  lnc_pkg::slot_t min_slot_r, min_slot_nxt;

  always_comb begin
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    free_nxt      = free_r;
    free_slot_nxt = free_slot_r;
    min_rank_nxt  = min_rank_r;
    min_slot_nxt  = min_slot_r;
    if (ctl.start) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
    end else if (ctl.step) begin
      if (ctl.slot_valid && node == target && !hit_r) begin
        hit_nxt      = 1'b1;
        hit_slot_nxt = ctl.idx;
      end
      if (!ctl.slot_valid && !free_r) begin
        free_nxt      = 1'b1;
        free_slot_nxt = ctl.idx;
      end
      if (ctl.idx == '0 || ctl.slot_rank < min_rank_r) begin
        min_rank_nxt = ctl.slot_rank;
        min_slot_nxt = ctl.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      hit_r  <= hit_nxt;
      free_r <= free_nxt;
    end
    hit_slot_r  <= hit_slot_nxt;
    free_slot_r <= free_slot_nxt;
    min_rank_r  <= min_rank_nxt;
    min_slot_r  <= min_slot_nxt;
  end

  assign res.hit        = hit_r;
  assign res.hit_slot   = hit_slot_r;
  assign res.free_found = free_r;
  assign res.free_slot  = free_slot_r;
  assign res.min_slot   = min_slot_r;

endmodule

[src/lru_node_cache_tags_core.sv]
// Top level of the node cache tag store: request sequencer, valid, dirty
// and recency state, output register. Depends on lnc_pkg, lnc_tag_ram and
// lnc_scan_unit.
//
// Fetch, create and mark-dirty requests scan every slot through one shared
// compare unit, one slot per cycle. On a hit or mark-dirty the result word
// is built in the decide state and enters the output register from the emit
// state, and the next request can be taken in the cycle after. A miss first
// passes a victim read state, reading the victim's node number from the tag
// memory. A null node id skips the scan: its word is built at accept and
// goes straight to the emit state. A flush emits one word per slot, each
// through a memory read, build and emit step; after the last word is loaded
// the next request can be taken in the cycle after. The emit step waits
// while the output stalls with a word still held.
// The input stalls until the last result word of a request is in the output
// register; that word may still wait there while the next request is taken.
module lru_node_cache_tags_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_node_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [3:0]  out_slot,
  output logic        out_read_from_store,
  output logic        out_clear_entry,
  output logic        out_write_back,
  output logic [30:0] out_write_id,
  output logic [3:0]  out_write_slot,
  output logic        out_null_ref,
  output logic        out_last
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DEC    = 3'd2;
  localparam logic [2:0] S_VRD    = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_FL_RD  = 3'd5;
  localparam logic [2:0] S_FL_OUT = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  lnc_pkg::cnt_t               cnt_r, cnt_nxt;
  logic [lnc_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  lnc_pkg::id_t                id_r, id_nxt;
  lnc_pkg::slot_t              vic_r, vic_nxt;
  logic                        step_r, step_nxt;
  lnc_pkg::slot_t              step_idx_r, step_idx_nxt;
  logic [lnc_pkg::SLOTS-1:0]   valid_r, valid_nxt;
  logic [lnc_pkg::SLOTS-1:0]   dirty_r, dirty_nxt;
  lnc_pkg::rank_t              rank_r [lnc_pkg::SLOTS];
  lnc_pkg::rank_t              rank_nxt [lnc_pkg::SLOTS];
  lnc_pkg::cnt_t               vcount_r, vcount_nxt;
  lnc_pkg::res_t               res_r, res_nxt;
  lnc_pkg::res_t               out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                        out_free;
  logic                        touch_en;
  lnc_pkg::slot_t              touch_s;
  lnc_pkg::cnt_t               others;
  lnc_pkg::slot_t              victim;
  logic                        wb;
  logic                        ram_we;
  lnc_pkg::slot_t              ram_raddr;
  lnc_pkg::id_t                ram_rdata;
  lnc_pkg::scan_ctl_t          sctl;
  lnc_pkg::scan_res_t          sres;

  lnc_tag_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (vic_r),
    .wdata (id_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sctl.start      = (state_r == S_IDLE) && in_valid;
  assign sctl.step       = step_r;
  assign sctl.idx        = step_idx_r;
  assign sctl.slot_valid = valid_r[step_idx_r];
  assign sctl.slot_rank  = rank_r[step_idx_r];

  lnc_scan_unit u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sctl),
    .node   (ram_rdata),
    .target (id_r),
    .res    (sres)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign victim   = sres.free_found ? sres.free_slot : sres.min_slot;
  assign wb       = valid_r[vic_r] && dirty_r[vic_r];
  assign others   = vcount_r - lnc_pkg::cnt_t'(valid_r[touch_s]);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    vic_nxt       = vic_r;
    step_nxt      = 1'b0;
    step_idx_nxt  = step_idx_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    vcount_nxt    = vcount_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    touch_en      = 1'b0;
    touch_s       = vic_r;
    ram_we        = 1'b0;
    ram_raddr     = cnt_r[lnc_pkg::SLOT_W-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          id_nxt   = in_node_id[lnc_pkg::ID_W-1:0];
          cnt_nxt  = '0;
          if (in_kind == lnc_pkg::KIND_FLUSH) begin
            state_nxt = S_FL_RD;
          end else if (in_node_id[31]) begin
            res_nxt          = '0;
            res_nxt.null_ref = (in_kind != lnc_pkg::KIND_MARK);
            res_nxt.last     = 1'b1;
            state_nxt        = S_EMIT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r < lnc_pkg::cnt_t'(lnc_pkg::SLOTS)) begin
          step_nxt     = 1'b1;
          step_idx_nxt = cnt_r[lnc_pkg::SLOT_W-1:0];
          cnt_nxt      = cnt_r + lnc_pkg::cnt_t'(1);
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        res_nxt      = '0;
        res_nxt.last = 1'b1;
        if (kind_r == lnc_pkg::KIND_MARK) begin
          if (sres.hit) begin
            dirty_nxt[sres.hit_slot] = 1'b1;
            res_nxt.hit              = 1'b1;
            res_nxt.slot             = lnc_pkg::OUT_SLOT_W'(sres.hit_slot);
          end
          state_nxt = S_EMIT;
        end else if (sres.hit) begin
          touch_en    = 1'b1;
          touch_s     = sres.hit_slot;
          if (kind_r == lnc_pkg::KIND_CREATE) begin
            dirty_nxt[sres.hit_slot] = 1'b1;
          end
          res_nxt.hit         = 1'b1;
          res_nxt.slot        = lnc_pkg::OUT_SLOT_W'(sres.hit_slot);
          res_nxt.clear_entry = (kind_r == lnc_pkg::KIND_CREATE);
          state_nxt           = S_EMIT;
        end else begin
          vic_nxt   = victim;
          ram_raddr = victim;
          state_nxt = S_VRD;
        end
      end
      S_VRD: begin
        touch_en                = 1'b1;
        touch_s                 = vic_r;
        dirty_nxt[vic_r]        = (kind_r == lnc_pkg::KIND_CREATE);
        ram_we                  = 1'b1;
        res_nxt                 = '0;
        res_nxt.slot            = lnc_pkg::OUT_SLOT_W'(vic_r);
        res_nxt.read_from_store = (kind_r == lnc_pkg::KIND_FETCH);
        res_nxt.clear_entry     = (kind_r == lnc_pkg::KIND_CREATE);
        res_nxt.write_back      = wb;
        res_nxt.write_id        = wb ? ram_rdata : '0;
        res_nxt.write_slot      = wb ? lnc_pkg::OUT_SLOT_W'(vic_r) : '0;
        res_nxt.last            = 1'b1;
        state_nxt               = S_EMIT;
      end
      S_FL_RD: begin
        state_nxt = S_FL_OUT;
      end
      S_FL_OUT: begin
        res_nxt      = '0;
        res_nxt.slot = lnc_pkg::OUT_SLOT_W'(cnt_r[lnc_pkg::SLOT_W-1:0]);
        if (valid_r[cnt_r[lnc_pkg::SLOT_W-1:0]] && dirty_r[cnt_r[lnc_pkg::SLOT_W-1:0]]) begin
          res_nxt.write_back = 1'b1;
          res_nxt.write_id   = ram_rdata;
          res_nxt.write_slot = lnc_pkg::OUT_SLOT_W'(cnt_r[lnc_pkg::SLOT_W-1:0]);
        end
        dirty_nxt[cnt_r[lnc_pkg::SLOT_W-1:0]] = 1'b0;
        res_nxt.last = (cnt_r == lnc_pkg::cnt_t'(lnc_pkg::SLOTS - 1));
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          if (kind_r == lnc_pkg::KIND_FLUSH && !res_r.last) begin
            cnt_nxt   = cnt_r + lnc_pkg::cnt_t'(1);
            state_nxt = S_FL_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    for (int i = 0; i < lnc_pkg::SLOTS; i++) begin
      rank_nxt[i] = rank_r[i];
      if (touch_en) begin
        if (lnc_pkg::slot_t'(i) == touch_s) begin
          rank_nxt[i] = others[lnc_pkg::SLOT_W-1:0];
        end else if (valid_r[i] && valid_r[touch_s] && rank_r[i] > rank_r[touch_s]) begin
          rank_nxt[i] = rank_r[i] - lnc_pkg::rank_t'(1);
        end
      end
    end
    if (touch_en && !valid_r[touch_s]) begin
      valid_nxt[touch_s] = 1'b1;
      vcount_nxt         = vcount_r + lnc_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      step_r      <= 1'b0;
      valid_r     <= '0;
      dirty_r     <= '0;
      vcount_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < lnc_pkg::SLOTS; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      vcount_r    <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < lnc_pkg::SLOTS; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
    kind_r     <= kind_nxt;
    id_r       <= id_nxt;
    vic_r      <= vic_nxt;
    step_idx_r <= step_idx_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_hit             = out_r.hit;
  assign out_slot            = out_r.slot;
  assign out_read_from_store = out_r.read_from_store;
  assign out_clear_entry     = out_r.clear_entry;
  assign out_write_back      = out_r.write_back;
  assign out_write_id        = out_r.write_id;
  assign out_write_slot      = out_r.write_slot;
  assign out_null_ref        = out_r.null_ref;
  assign out_last            = out_r.last;

endmodule
